### sv/cgt_pkg.sv
package cgt_pkg;

	localparam int TableEntriesDef = 1024;
	localparam int MaxStopsDef     = 16;
	localparam int PosW            = 17;
	localparam int ColW            = 8;
	localparam int IdxW            = 10;
	localparam int CntW            = 5;
	localparam logic [PosW-1:0] PosOne = 17'h10000;
	localparam logic [0:0] AddrLocked = 1'b0;

	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_READ   = 2'd3
	} func_t;

	// item passed from front to back
	typedef struct packed {
		func_t           func;
		logic [PosW-1:0] pos;
		logic [ColW-1:0] red;
		logic [ColW-1:0] green;
		logic [ColW-1:0] blue;
		logic [IdxW-1:0] idx;
		logic            locked;
	} item_t;

	// one result
	typedef struct packed {
		logic [ColW-1:0] red;
		logic [ColW-1:0] green;
		logic [ColW-1:0] blue;
		logic            scale_valid;
		logic            refused;
		logic [CntW-1:0] total;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SETUP,
		ST_PROD,
		ST_DIV,
		ST_MIX,
		ST_DONE
	} state_t;

endpackage

### sv/cgt_front.sv
module cgt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [55:0]        s_tdata,
	input  logic               locked,
	output logic               q_valid,
	input  logic               q_ready,
	output cgt_pkg::item_t     q_item
);
	import cgt_pkg::*;

	localparam int Depth = 2;

	item_t    mem_q [Depth];
	logic [0:0] wr_q, rd_q;
	logic [1:0] cnt_q;
	item_t    in_item;
	logic     push, pop;

	// unpack the incoming transfer
	always_comb begin
		in_item.func   = func_t'(s_tdata[1:0]);
		in_item.pos    = s_tdata[18:2];
		in_item.red    = s_tdata[26:19];
		in_item.green  = s_tdata[34:27];
		in_item.blue   = s_tdata[42:35];
		in_item.idx    = s_tdata[52:43];
		in_item.locked = locked;
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_q];

	// small queue between the two halves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overflow");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !s_tready) else $error("accept while full");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && cnt_q != 2'd2) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("count slip");
`endif
endmodule

### sv/cgt_back.sv
module cgt_back #(
	parameter int TABLE_ENTRIES = cgt_pkg::TableEntriesDef,
	parameter int MAX_STOPS     = cgt_pkg::MaxStopsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  cgt_pkg::item_t    q_item,
	output logic              m_tvalid,
	input  logic              m_tready,
	output cgt_pkg::result_t  m_res
);
	import cgt_pkg::*;

	localparam int SW   = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int EW   = $clog2(TABLE_ENTRIES);
	localparam int SpW  = $clog2(TABLE_ENTRIES);
	localparam int PW   = PosW + SpW + 1;          // scaled position
	localparam int TW   = EW + 17;                  // target
	localparam int WW   = (PW > TW) ? PW : TW;      // working width
	localparam int NW   = WW + ColW;                // colour step times offset
	localparam logic [SpW-1:0] Span = SpW'(TABLE_ENTRIES - 1);
	localparam logic [EW-1:0]  LastEntry = EW'(TABLE_ENTRIES - 1);

	// stop store, shifting register file
	logic [PosW-1:0] pos_q [MAX_STOPS];
	logic [ColW-1:0] red_q [MAX_STOPS];
	logic [ColW-1:0] grn_q [MAX_STOPS];
	logic [ColW-1:0] blu_q [MAX_STOPS];
	logic [SW:0]     count_q;

	state_t state_q, state_d;
	item_t  it_q;
	logic [SW-1:0] k_q;
	logic [WW-1:0] tgt_q, num_q, den_q;
	logic [NW-1:0] nr_q, ng_q, nb_q, dsh_q;
	logic [ColW-1:0] dr_q, dg_q, db_q;
	logic [ColW-1:0] qr_q, qg_q, qb_q;
	logic [2:0]    neg_q;
	logic [2:0]    bit_q;
	logic          zero_q;
	logic          out_valid_q;
	result_t       out_q;

	logic scale_ok;
	logic [SW:0] cnt_w;
	logic [WW-1:0] p1s, p0s;
	logic [EW-1:0] eidx;
	logic [SW-1:0] j1;

	assign cnt_w = count_q;
	assign scale_ok = (cnt_w >= (SW+1)'(2)) && (pos_q[0] == '0)
		&& (pos_q[SW'(cnt_w - 1'b1)] == PosOne);
	assign q_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_res = out_q;
	assign j1 = k_q + 1'b1;
	assign p1s = WW'(pos_q[j1]) * WW'(Span);
	assign p0s = WW'(pos_q[k_q]) * WW'(Span);

	// clamp index to the table
	always_comb begin
		if (int'(q_item.idx) >= TABLE_ENTRIES) eidx = LastEntry;
		else eidx = EW'(q_item.idx);
	end

	// earlier colour plus or minus the exact step, rounded down
	function automatic logic [ColW-1:0] blend(input logic [ColW-1:0] c0,
			input logic [ColW-1:0] q, input logic frac, input logic neg, input logic z);
		begin
			if (z) blend = c0;
			else if (neg) blend = c0 - q - ColW'(frac);
			else blend = c0 + q;
		end
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (q_valid && !out_valid_q) state_d = ST_SEARCH;
			ST_SEARCH: begin
				if (it_q.func != FUNC_READ) state_d = ST_DONE;
				else if (!scale_ok) state_d = ST_DONE;
				else if ((SW+1)'(k_q) + 2 < cnt_w && p1s < tgt_q) state_d = ST_SEARCH;
				else state_d = ST_SETUP;
			end
			ST_SETUP:  state_d = ST_PROD;
			ST_PROD:   state_d = ST_DIV;
			ST_DIV:    if (bit_q == 3'd0) state_d = ST_MIX;
			ST_MIX:    state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && m_tready) out_valid_q <= 1'b0;
			if (state_q == ST_DONE) out_valid_q <= 1'b1;
			if (state_q == ST_SEARCH) begin
				case (it_q.func)
					FUNC_APPEND: if (!it_q.locked && cnt_w < (SW+1)'(MAX_STOPS))
						count_q <= count_q + 1'b1;
					FUNC_REMOVE: if (!it_q.locked && it_q.idx < IdxW'(count_q))
						count_q <= count_q - 1'b1;
					FUNC_CLEAR:  if (!it_q.locked) count_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// datapath and store edits
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (q_valid && !out_valid_q) begin
				it_q  <= q_item;
				k_q   <= '0;
				tgt_q <= WW'({eidx, 16'b0});
				out_q <= '0;
			end
			ST_SEARCH: begin
				out_q.refused <= 1'b0;
				case (it_q.func)
					FUNC_APPEND: begin
						if (it_q.locked || cnt_w >= (SW+1)'(MAX_STOPS)) out_q.refused <= 1'b1;
						else begin
							for (int i = MAX_STOPS - 1; i >= 0; i--) begin
								if ((SW+1)'(i) <= cnt_w) begin
									if (i > 0 && (SW+1)'(i) <= cnt_w && pos_q[(i>0)?i-1:0] > it_q.pos
										&& (SW+1)'(i) <= cnt_w) begin
										pos_q[i] <= pos_q[(i>0)?i-1:0];
										red_q[i] <= red_q[(i>0)?i-1:0];
										grn_q[i] <= grn_q[(i>0)?i-1:0];
										blu_q[i] <= blu_q[(i>0)?i-1:0];
									end
									if ((i == 0 || pos_q[(i>0)?i-1:0] <= it_q.pos
										|| (SW+1)'(i) == 0)
										&& ((SW+1)'(i) == cnt_w || pos_q[i] > it_q.pos)) begin
										pos_q[i] <= it_q.pos;
										red_q[i] <= it_q.red;
										grn_q[i] <= it_q.green;
										blu_q[i] <= it_q.blue;
									end
								end
							end
						end
					end
					FUNC_REMOVE: begin
						if (it_q.locked || it_q.idx >= IdxW'(count_q)) out_q.refused <= 1'b1;
						else begin
							for (int i = 0; i < MAX_STOPS - 1; i++) begin
								if (IdxW'(i) >= it_q.idx) begin
									pos_q[i] <= pos_q[i+1];
									red_q[i] <= red_q[i+1];
									grn_q[i] <= grn_q[i+1];
									blu_q[i] <= blu_q[i+1];
								end
							end
						end
					end
					FUNC_CLEAR: out_q.refused <= it_q.locked;
					default: if (scale_ok && (SW+1)'(k_q) + 2 < cnt_w && p1s < tgt_q)
						k_q <= k_q + 1'b1;
				endcase
			end
			ST_SETUP: begin
				// offset into the interval, its width and the colour steps
				num_q    <= tgt_q - p0s;
				den_q    <= p1s - p0s;
				zero_q   <= (p1s == p0s);
				dr_q     <= (red_q[j1] >= red_q[k_q]) ? red_q[j1] - red_q[k_q]
					: red_q[k_q] - red_q[j1];
				dg_q     <= (grn_q[j1] >= grn_q[k_q]) ? grn_q[j1] - grn_q[k_q]
					: grn_q[k_q] - grn_q[j1];
				db_q     <= (blu_q[j1] >= blu_q[k_q]) ? blu_q[j1] - blu_q[k_q]
					: blu_q[k_q] - blu_q[j1];
				neg_q[0] <= red_q[j1] < red_q[k_q];
				neg_q[1] <= grn_q[j1] < grn_q[k_q];
				neg_q[2] <= blu_q[j1] < blu_q[k_q];
			end
			ST_PROD: begin
				nr_q  <= NW'(dr_q) * NW'(num_q);
				ng_q  <= NW'(dg_q) * NW'(num_q);
				nb_q  <= NW'(db_q) * NW'(num_q);
				dsh_q <= NW'(den_q) << (ColW - 1);
				qr_q  <= '0;
				qg_q  <= '0;
				qb_q  <= '0;
				bit_q <= 3'(ColW - 1);
			end
			ST_DIV: begin
				// restoring division, one quotient bit a cycle for each colour
				bit_q <= bit_q - 1'b1;
				dsh_q <= dsh_q >> 1;
				if (nr_q >= dsh_q) begin
					nr_q <= nr_q - dsh_q;
					qr_q <= {qr_q[ColW-2:0], 1'b1};
				end else qr_q <= {qr_q[ColW-2:0], 1'b0};
				if (ng_q >= dsh_q) begin
					ng_q <= ng_q - dsh_q;
					qg_q <= {qg_q[ColW-2:0], 1'b1};
				end else qg_q <= {qg_q[ColW-2:0], 1'b0};
				if (nb_q >= dsh_q) begin
					nb_q <= nb_q - dsh_q;
					qb_q <= {qb_q[ColW-2:0], 1'b1};
				end else qb_q <= {qb_q[ColW-2:0], 1'b0};
			end
			ST_MIX: begin
				out_q.red   <= blend(red_q[k_q], qr_q, nr_q != '0, neg_q[0], zero_q);
				out_q.green <= blend(grn_q[k_q], qg_q, ng_q != '0, neg_q[1], zero_q);
				out_q.blue  <= blend(blu_q[k_q], qb_q, nb_q != '0, neg_q[2], zero_q);
			end
			ST_DONE: begin
				out_q.scale_valid <= scale_ok;
				out_q.total       <= CntW'(count_q);
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (SW+1)'(MAX_STOPS)) else $error("stop count overflow");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> state_q == ST_IDLE) else $error("ready out of idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(out_q))
		else $error("result dropped");
`endif
endmodule

### sv/color_gradient_table_unit.sv
// Colour gradient table: keeps up to MAX_STOPS colour stops sorted by position and answers
// reads of a TABLE_ENTRIES-entry linear gradient. A front queue of two items takes
// transfers while the back end works; the back end takes one item at a time and starts
// the next only once the result transfer has gone. An edit skips the divider; a table read
// steps the interval search past one stop at a time (at most stop_count - 2 steps), then runs
// the divider that works out the blend exactly. One result per item.
module color_gradient_table_unit #(
	parameter int TABLE_ENTRIES = cgt_pkg::TableEntriesDef,
	parameter int MAX_STOPS     = cgt_pkg::MaxStopsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // func, stop_pos, red_in, green_in, blue_in, entry_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // red_out, green_out, blue_out, scale_valid, refused, stop_total
);
	import cgt_pkg::*;

	logic locked_q;
	logic q_valid, q_ready;
	item_t q_item;
	result_t res;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) locked_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == AddrLocked) locked_q <= pwdata[0];
	end
	assign pready = 1'b1;
	assign prdata = {31'b0, locked_q};

	cgt_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.locked(locked_q), .q_valid, .q_ready, .q_item
	);

	cgt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_STOPS(MAX_STOPS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.m_tvalid, .m_tready, .m_res(res)
	);

	assign m_tdata = {9'b0, res.total, res.refused, res.scale_valid,
		res.blue, res.green, res.red};
endmodule
